@@ hw/rtl/bti_pkg.sv @@
// Shared widths, grid constants and the fixed fall-time table of the interpolator.
package bti_pkg;

    localparam int TEMP_W  = 13;
    localparam int GRAIN_W = 10;
    localparam int FT_W    = 20;

    localparam int TEMP_POINTS_DEF  = 21;
    localparam int GRAIN_POINTS_DEF = 5;

    localparam int TEMP_STEP  = 256;
    localparam int GRAIN_BASE = 100;
    localparam int GRAIN_STEP = 100;

    // Width of a table row or column address, enough for the largest grid.
    localparam int IDX_W = 6;

    localparam int ROM_ROWS = 21;
    localparam int ROM_COLS = 5;

    // Fall time in Q12.8, rows by temperature, columns by grain diameter.
    localparam logic [FT_W-1:0] FT_ROM [ROM_ROWS][ROM_COLS] = '{
        '{20'd508601, 20'd127150, 20'd56511, 20'd31788, 20'd20344},
        '{20'd491789, 20'd122947, 20'd54643, 20'd30737, 20'd19672},
        '{20'd475796, 20'd118949, 20'd52866, 20'd29737, 20'd19032},
        '{20'd460571, 20'd115143, 20'd51174, 20'd28786, 20'd18423},
        '{20'd446067, 20'd111517, 20'd49563, 20'd27879, 20'd17843},
        '{20'd432241, 20'd108060, 20'd48027, 20'd27015, 20'd17290},
        '{20'd419053, 20'd104763, 20'd46562, 20'd26191, 20'd16762},
        '{20'd406466, 20'd101617, 20'd45163, 20'd25404, 20'd16259},
        '{20'd394445, 20'd98611,  20'd43827, 20'd24653, 20'd15778},
        '{20'd382956, 20'd95739,  20'd42551, 20'd23935, 20'd15318},
        '{20'd371971, 20'd92993,  20'd41330, 20'd23248, 20'd14879},
        '{20'd361461, 20'd90365,  20'd40162, 20'd22591, 20'd14458},
        '{20'd351400, 20'd87850,  20'd39045, 20'd21962, 20'd14056},
        '{20'd341763, 20'd85441,  20'd37974, 20'd21360, 20'd13670},
        '{20'd332527, 20'd83132,  20'd36947, 20'd20783, 20'd13301},
        '{20'd323672, 20'd80918,  20'd35964, 20'd20229, 20'd12947},
        '{20'd315176, 20'd78794,  20'd35020, 20'd19699, 20'd12607},
        '{20'd307021, 20'd76755,  20'd34114, 20'd19189, 20'd12281},
        '{20'd299190, 20'd74798,  20'd33243, 20'd18699, 20'd11967},
        '{20'd291665, 20'd72916,  20'd32407, 20'd18229, 20'd11667},
        '{20'd284433, 20'd71108,  20'd31604, 20'd17777, 20'd11377}
    };

    // Grid points outside the stored table read as zero.
    function automatic logic [FT_W-1:0] ft_lookup(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
        logic [FT_W-1:0] val;
        val = '0;
        if (row < IDX_W'(ROM_ROWS) && col < IDX_W'(ROM_COLS))
        begin
            val = FT_ROM[row[4:0]][col[2:0]];
        end
        return val;
    endfunction

endpackage

@@ hw/rtl/bilinear_table_interpolator_unit.sv @@
// Five-stage pipeline that clamps a query to the grid and blends four table corners.

// The unit takes one temperature and grain-size word per clock while req_ready is high and
// presents one fall-time word per query, in order, from the stage-five register once the
// query has moved through every stage. Every stage is a register slot with its
// own valid bit, so a stall at the output only fills empty slots and nothing is
// dropped or repeated. The sustained rate of one word per cycle holds while the output is
// not stalled, because every stage then hands its word on at each clock; the deepest
// stage, one 27 by 28 bit multiply for the exact divide by 25600, sets the clock
// period. Stage one clamps and finds the grid cell, stage two reads the four corners
// from the constant table and forms the area weights, stage three multiplies, stage
// four sums with rounding, and stage five divides. Inputs off the grid are clamped to
// its edge and flagged with out_of_range.
module bilinear_table_interpolator_unit #(
    parameter int TEMP_POINTS  = bti_pkg::TEMP_POINTS_DEF,
    parameter int GRAIN_POINTS = bti_pkg::GRAIN_POINTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [bti_pkg::TEMP_W-1:0]  temperature,
    input  logic [bti_pkg::GRAIN_W-1:0] grain_size,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [bti_pkg::FT_W-1:0]    fall_time,
    output logic                        out_of_range
);
    import bti_pkg::*;

    localparam int RW    = $clog2(TEMP_POINTS);
    localparam int CW    = $clog2(GRAIN_POINTS);
    localparam int TMAX  = (TEMP_POINTS - 1) * TEMP_STEP;
    localparam int GSPAN = (GRAIN_POINTS - 1) * GRAIN_STEP;
    localparam int W_W   = 15;  // largest area weight is 25600
    localparam int P_W   = 35;  // weight times corner, and the sum of four
    localparam int X_W   = P_W - 8;
    localparam int RECIP_SH = 34;
    // ceil(2^34 / 100): exact floor division for any 27-bit dividend.
    localparam logic [27:0] RECIP = 28'(((64'd1 << RECIP_SH) + 64'd99) / 64'd100);
    localparam logic [P_W-1:0] ROUND_HALF = P_W'(TEMP_STEP * GRAIN_STEP / 2);

    // Stage enables: a slot loads when it is empty or its word moves on.
    logic en1, en2, en3, en4, en5;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // Stage one: clamp and locate the cell.
    logic [TEMP_W-1:0]  tq;
    logic               t_over;
    logic [4:0]         row_raw;
    logic               row_top;
    logic [GRAIN_W-1:0] goff;
    logic               g_low, g_over;
    logic [15:0]        col_prod;
    logic [3:0]         col_raw;
    logic               col_top;
    logic [GRAIN_W-1:0] col_base;

    logic [RW-1:0] row_next;
    logic [CW-1:0] col_next;
    logic [8:0]    t_next;
    logic [6:0]    u_next;
    logic          flag_next;

    logic [RW-1:0] s1_row_reg;
    logic [CW-1:0] s1_col_reg;
    logic [8:0]    s1_t_reg;
    logic [6:0]    s1_u_reg;
    logic          s1_flag_reg;

    always_comb
    begin
        t_over = 32'(temperature) > TMAX;
        tq     = t_over ? TEMP_W'(TMAX) : temperature;

        row_raw = tq[TEMP_W-1:8];
        row_top = 32'(row_raw) > (TEMP_POINTS - 2);
        row_next = row_top ? RW'(TEMP_POINTS - 2) : RW'(row_raw);
        // The row is only pulled down when the temperature sits on the last grid point.
        t_next = row_top ? 9'(TEMP_STEP) : {1'b0, tq[7:0]};

        g_low  = 32'(grain_size) < GRAIN_BASE;
        goff   = g_low ? '0 : grain_size - GRAIN_W'(GRAIN_BASE);
        g_over = 32'(goff) > GSPAN;
        if (g_over)
        begin
            goff = GRAIN_W'(GSPAN);
        end

        // Multiply by 41/4096 gives the exact quotient by 100 for all 10-bit values.
        col_prod = 16'(goff) * 16'd41;
        col_raw  = col_prod[15:12];
        col_top  = 32'(col_raw) > (GRAIN_POINTS - 2);
        col_next = col_top ? CW'(GRAIN_POINTS - 2) : CW'(col_raw);
        col_base = GRAIN_W'(col_raw) * GRAIN_W'(GRAIN_STEP);
        u_next   = col_top ? 7'(GRAIN_STEP) : 7'(goff - col_base);

        flag_next = t_over | g_low | g_over;
    end

    // Stage two: corners and area weights.
    logic [IDX_W-1:0] r0, r1, c0, c1;
    logic [8:0]       wt0, wt1;
    logic [6:0]       wu0, wu1;

    logic [FT_W-1:0] s2_y00_reg, s2_y10_reg, s2_y11_reg, s2_y01_reg;
    logic [W_W-1:0]  s2_w00_reg, s2_w10_reg, s2_w11_reg, s2_w01_reg;
    logic            s2_flag_reg;

    always_comb
    begin
        r0  = IDX_W'(s1_row_reg);
        r1  = IDX_W'(s1_row_reg) + IDX_W'(1);
        c0  = IDX_W'(s1_col_reg);
        c1  = IDX_W'(s1_col_reg) + IDX_W'(1);
        wt1 = s1_t_reg;
        wt0 = 9'(TEMP_STEP) - s1_t_reg;
        wu1 = s1_u_reg;
        wu0 = 7'(GRAIN_STEP) - s1_u_reg;
    end

    // Stage three: weighted corners.
    logic [P_W-1:0] s3_p00_reg, s3_p10_reg, s3_p11_reg, s3_p01_reg;
    logic           s3_flag_reg;

    // Stage four: rounded sum.
    logic [P_W-1:0] s4_sum_reg;
    logic           s4_flag_reg;

    // Stage five: divide by 25600 as a shift and an exact reciprocal multiply.
    logic [X_W-1:0]    quot_in;
    logic [X_W+27:0]   quot_prod;
    logic [FT_W-1:0]   ft_reg;
    logic              oor_reg;

    assign quot_in   = s4_sum_reg[P_W-1:8];
    assign quot_prod = (X_W+28)'(quot_in) * (X_W+28)'(RECIP);

    assign en5       = ~v5_reg | rsp_ready;
    assign en4       = ~v4_reg | en5;
    assign en3       = ~v3_reg | en4;
    assign en2       = ~v2_reg | en3;
    assign en1       = ~v1_reg | en2;
    assign req_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= req_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_row_reg  <= row_next;
            s1_col_reg  <= col_next;
            s1_t_reg    <= t_next;
            s1_u_reg    <= u_next;
            s1_flag_reg <= flag_next;
        end
        if (en2)
        begin
            s2_y00_reg  <= ft_lookup(r0, c0);
            s2_y10_reg  <= ft_lookup(r1, c0);
            s2_y11_reg  <= ft_lookup(r1, c1);
            s2_y01_reg  <= ft_lookup(r0, c1);
            s2_w00_reg  <= W_W'(16'(wt0) * 16'(wu0));
            s2_w10_reg  <= W_W'(16'(wt1) * 16'(wu0));
            s2_w11_reg  <= W_W'(16'(wt1) * 16'(wu1));
            s2_w01_reg  <= W_W'(16'(wt0) * 16'(wu1));
            s2_flag_reg <= s1_flag_reg;
        end
        if (en3)
        begin
            s3_p00_reg  <= P_W'(s2_w00_reg) * P_W'(s2_y00_reg);
            s3_p10_reg  <= P_W'(s2_w10_reg) * P_W'(s2_y10_reg);
            s3_p11_reg  <= P_W'(s2_w11_reg) * P_W'(s2_y11_reg);
            s3_p01_reg  <= P_W'(s2_w01_reg) * P_W'(s2_y01_reg);
            s3_flag_reg <= s2_flag_reg;
        end
        if (en4)
        begin
            // The weights sum to 25600, so the total is at most the largest corner times that plus the rounding half.
            s4_sum_reg  <= s3_p00_reg + s3_p10_reg + s3_p11_reg + s3_p01_reg + ROUND_HALF;
            s4_flag_reg <= s3_flag_reg;
        end
        if (en5)
        begin
            ft_reg  <= quot_prod[RECIP_SH +: FT_W];
            oor_reg <= s4_flag_reg;
        end
    end

    assign rsp_valid    = v5_reg;
    assign fall_time    = ft_reg;
    assign out_of_range = oor_reg;

endmodule
